// ----- hw/rtl/epd_pkg.sv -----
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types and constants for the event packet deframer.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned EVENT_BYTES  = 12;
  localparam int unsigned NUM_WORDS    = 5;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_COUNT  = 2'd1,
    PH_EVENT  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [31:0]                 seq_number;
    logic [7:0]                  event_cmd;
    logic [7:0]                  event_src;
    logic [NUM_WORDS-1:0][15:0]  words;
    logic                        has_event;
    logic                        packet_end;
    logic                        truncated;
  } result_t;

endpackage

// ----- hw/rtl/epd_parser.sv -----
// ----------------------------------------------------------------------------
// epd_parser
// Byte-wise packet parser: tracks header, count and event phases and forms
// one result for each byte that completes an event or ends the packet.
// ----------------------------------------------------------------------------
module epd_parser
  import epd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_step, phase_next;
  logic [3:0]  byte_index, byte_index_next, index_inc;
  logic [31:0] seq_reg, seq_reg_next;
  logic [15:0] events_left, events_left_next;
  logic [7:0]  count_high, count_high_next;
  logic [7:0]  cmd_reg, cmd_reg_next;
  logic [7:0]  src_reg, src_reg_next;
  logic [7:0]  word_high, word_high_next;
  logic [NUM_WORDS-1:0][15:0] word_store, word_store_next;
  logic [2:0]  word_sel;
  logic        done_event;

  assign index_inc = byte_index + 4'd1;
  assign word_sel  = 3'((byte_index - 4'd3) >> 1);

  // Phase sequencing; the phase after this byte decides truncation.
  always_comb begin
    phase_step = phase;
    case (phase)
      PH_COUNT: begin
        if (byte_index != 4'd0) begin
          phase_step = ({count_high, data_byte} != 16'd0) ? PH_EVENT : PH_COUNT;
        end
      end
      PH_EVENT: begin
        if (index_inc >= 4'(EVENT_BYTES) && events_left == 16'd1) begin
          phase_step = PH_COUNT;
        end
      end
      default: begin
        phase_step = (index_inc >= 4'(HEADER_BYTES)) ? PH_COUNT : PH_HEADER;
      end
    endcase
    phase_next = last_byte ? PH_HEADER : phase_step;
  end

  // Field capture and counters.
  always_comb begin
    byte_index_next  = byte_index;
    seq_reg_next     = seq_reg;
    events_left_next = events_left;
    count_high_next  = count_high;
    cmd_reg_next     = cmd_reg;
    src_reg_next     = src_reg;
    word_high_next   = word_high;
    word_store_next  = word_store;
    done_event       = 1'b0;
    case (phase)
      PH_COUNT: begin
        if (byte_index == 4'd0) begin
          count_high_next = data_byte;
          byte_index_next = 4'd1;
        end else begin
          events_left_next = {count_high, data_byte};
          byte_index_next  = 4'd0;
        end
      end
      PH_EVENT: begin
        if (byte_index == 4'd0) begin
          cmd_reg_next = data_byte;
        end else if (byte_index == 4'd1) begin
          src_reg_next = data_byte;
        end else if (!byte_index[0]) begin
          word_high_next = data_byte;
        end else begin
          for (int k = 0; k < NUM_WORDS; k++) begin
            if (word_sel == 3'(k)) begin
              word_store_next[k] = {word_high, data_byte};
            end
          end
        end
        if (index_inc >= 4'(EVENT_BYTES)) begin
          done_event       = 1'b1;
          byte_index_next  = 4'd0;
          events_left_next = events_left - 16'd1;
        end else begin
          byte_index_next = index_inc;
        end
      end
      default: begin
        seq_reg_next    = {seq_reg[23:0], data_byte};
        byte_index_next = (index_inc >= 4'(HEADER_BYTES)) ? 4'd0 : index_inc;
      end
    endcase
    if (last_byte) begin
      byte_index_next  = 4'd0;
      events_left_next = 16'd0;
    end
  end

  always_comb begin
    res            = '0;
    res_valid      = accept && (done_event || last_byte);
    res.seq_number = seq_reg_next;
    if (done_event) begin
      res.event_cmd = cmd_reg_next;
      res.event_src = src_reg_next;
      res.words     = word_store_next;
      res.has_event = 1'b1;
    end
    if (last_byte) begin
      res.packet_end = 1'b1;
      res.truncated  = (phase_step != PH_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      byte_index  <= 4'd0;
      seq_reg     <= 32'd0;
      events_left <= 16'd0;
      count_high  <= 8'd0;
      cmd_reg     <= 8'd0;
      src_reg     <= 8'd0;
      word_high   <= 8'd0;
      word_store  <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      seq_reg     <= seq_reg_next;
      events_left <= events_left_next;
      count_high  <= count_high_next;
      cmd_reg     <= cmd_reg_next;
      src_reg     <= src_reg_next;
      word_high   <= word_high_next;
      word_store  <= word_store_next;
    end
  end

endmodule

// ----- hw/rtl/event_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// event_packet_deframer
// Deframes event packets arriving one byte per request into event results.
// ----------------------------------------------------------------------------
// Output: the result of an accepted byte is registered into the output
// register, or into the skid register while the output is held.
// Throughput: one byte per cycle while in_stall is low; a one-entry skid register behind
// the output register catches a result made while the output is held, and then raises in_stall.
// Reset: synchronous rst returns the parser to the header phase, clears all
// counters and empties the output and skid registers.
module event_packet_deframer
  import epd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] seq_number,
  output logic [7:0]  event_cmd,
  output logic [7:0]  event_src,
  output logic [15:0] word0,
  output logic [15:0] word1,
  output logic [15:0] word2,
  output logic [15:0] word3,
  output logic [15:0] word4,
  output logic        has_event,
  output logic        packet_end,
  output logic        truncated
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  epd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register with a skid entry that catches a result produced while
  // the output is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (res_valid) begin
      skid_data <= res;
    end
  end

  assign seq_number = out_data.seq_number;
  assign event_cmd  = out_data.event_cmd;
  assign event_src  = out_data.event_src;
  assign word0      = out_data.words[0];
  assign word1      = out_data.words[1];
  assign word2      = out_data.words[2];
  assign word3      = out_data.words[3];
  assign word4      = out_data.words[4];
  assign has_event  = out_data.has_event;
  assign packet_end = out_data.packet_end;
  assign truncated  = out_data.truncated;

endmodule

// ----- hw/rtl/epd_checker.sv -----
// ----------------------------------------------------------------------------
// epd_checker
// Port-level checks for the event packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module epd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] seq_number,
  input logic [7:0]  event_cmd,
  input logic [7:0]  event_src,
  input logic [15:0] word0,
  input logic [15:0] word4,
  input logic        has_event,
  input logic        packet_end,
  input logic        truncated
);

  // Every result carries an event, a packet end, or both.
  a_result_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_event || packet_end))
    else $error("result without event or packet end");

  // Truncation is only reported on the packet's final request.
  a_trunc_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated) |-> packet_end)
    else $error("truncated without packet_end");

  // Event fields read as zero when no event completed.
  a_empty_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_event) |->
      (event_cmd == 8'd0 && event_src == 8'd0 && word0 == 16'd0 && word4 == 16'd0))
    else $error("event fields nonzero without event");

  // The input stall clears once the output drains.
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    (in_stall && !out_stall) |=> !in_stall)
    else $error("input stall held after output drained");

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(seq_number) && $stable(packet_end)))
    else $error("stalled result changed");

endmodule

bind event_packet_deframer epd_checker u_epd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .seq_number (seq_number),
  .event_cmd  (event_cmd),
  .event_src  (event_src),
  .word0      (word0),
  .word4      (word4),
  .has_event  (has_event),
  .packet_end (packet_end),
  .truncated  (truncated)
);
